[sv/wsp_pkg.sv]
// Package for the wheel synchronizer drive: widths, register codes, reset values,
// sequencer step schedule and the structs passed between the block's modules.
// No dependencies.
`default_nettype none

package wsp_pkg;

   // Count and gain format
   localparam int COUNT_BITS     = 24;
   localparam int GAIN_FRAC_BITS = 24;

   // Register and port widths
   localparam int TARGET_W   = 23;
   localparam int SPEED_W    = 16;
   localparam int GAIN_W     = 24;
   localparam int CAP_W      = 15;
   localparam int DRIVE_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Datapath widths
   localparam int CMP_W      = COUNT_BITS + 2;
   localparam int ERR_W      = COUNT_BITS + 1;
   localparam int DIFF_W     = ERR_W + 1;
   localparam int SUM_W      = 40;
   localparam int RATIO_W    = 4;
   localparam int MUL_W      = 24;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int ACC_W      = 64;
   localparam int MAG_W      = 2 * MUL_W;
   localparam int TERM_SHIFT = GAIN_FRAC_BITS - 15;
   localparam int TERM_W     = DIFF_W + GAIN_W - TERM_SHIFT;
   localparam int LSUM_W     = TERM_W + 2;
   localparam int CLAMP_W    = 20;
   localparam int QUOT_W     = 20;

   // Divide by ten as multiply by reciprocal, exact for operands below 2^23
   localparam int RECIP_SHIFT = 26;
   localparam logic [MUL_W-1:0] RECIP_TEN = MUL_W'(6710887);

   // Speed ratio in tenths
   localparam logic [RATIO_W-1:0] RATIO_START = RATIO_W'(3);
   localparam logic [RATIO_W-1:0] RATIO_MAX   = RATIO_W'(10);
   localparam logic [RATIO_W-1:0] RATIO_FLOOR = RATIO_W'(3);

   // Register reset values
   localparam logic [TARGET_W-1:0] TARGET_RST = TARGET_W'(13367);
   localparam logic [SPEED_W-1:0]  SPEED_RST  = SPEED_W'(13107);
   localparam logic [GAIN_W-1:0]   GAIN_P_RST = GAIN_W'(21810);
   localparam logic [GAIN_W-1:0]   GAIN_I_RST = GAIN_W'(7214);
   localparam logic [GAIN_W-1:0]   GAIN_D_RST = GAIN_W'(1174);
   localparam logic [CAP_W-1:0]    CAP_RST    = CAP_W'(1311);
   localparam logic [TARGET_W-1:0] MARGIN_RST = TARGET_W'(5347);

   // Register index codes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET = CSR_IDX_W'(0),
      CSR_SPEED  = CSR_IDX_W'(1),
      CSR_GAIN_P = CSR_IDX_W'(2),
      CSR_GAIN_I = CSR_IDX_W'(3),
      CSR_GAIN_D = CSR_IDX_W'(4),
      CSR_CAP    = CSR_IDX_W'(5),
      CSR_MARGIN = CSR_IDX_W'(6)
   } csr_idx_type;

   // Item mode codes
   localparam logic MODE_START = 1'b0;

   // Step schedule of one control tick
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_P_LO  = STEP_W'(0);
   localparam logic [STEP_W-1:0] STEP_P_HI  = STEP_W'(1);
   localparam logic [STEP_W-1:0] STEP_D_LO  = STEP_W'(2);
   localparam logic [STEP_W-1:0] STEP_D_HI  = STEP_W'(3);
   localparam logic [STEP_W-1:0] STEP_I_LO  = STEP_W'(4);
   localparam logic [STEP_W-1:0] STEP_I_HI  = STEP_W'(5);
   localparam logic [STEP_W-1:0] STEP_USE_P = STEP_W'(3);
   localparam logic [STEP_W-1:0] STEP_USE_D = STEP_W'(5);
   localparam logic [STEP_W-1:0] STEP_USE_I = STEP_W'(7);
   localparam logic [STEP_W-1:0] STEP_CLAMP = STEP_W'(8);
   localparam logic [STEP_W-1:0] STEP_MUL_R = STEP_W'(9);
   localparam logic [STEP_W-1:0] STEP_MUL_L = STEP_W'(10);
   localparam logic [STEP_W-1:0] STEP_DIV_R = STEP_W'(11);
   localparam logic [STEP_W-1:0] STEP_DIV_L = STEP_W'(12);
   localparam logic [STEP_W-1:0] STEP_OUT_R = STEP_W'(13);
   localparam logic [STEP_W-1:0] STEP_OUT_L = STEP_W'(14);
   localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(14);

   // Register file contents
   typedef struct packed {
      logic [TARGET_W-1:0] target;
      logic [SPEED_W-1:0]  base_speed;
      logic [GAIN_W-1:0]   gain_p;
      logic [GAIN_W-1:0]   gain_i;
      logic [GAIN_W-1:0]   gain_d;
      logic [CAP_W-1:0]    integral_cap;
      logic [TARGET_W-1:0] decel_margin;
   } wsp_cfg_type;

   // Sequencer controls to the datapath
   typedef struct packed {
      logic              accept;
      logic              eval;
      logic              prep;
      logic              mags;
      logic              run;
      logic [STEP_W-1:0] step;
      logic              load_out;
   } wsp_ctl_type;

   // One multiply issue to the shared unit
   typedef struct packed {
      logic             valid;
      logic             acc_hi;
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
   } wsp_mul_cmd_type;

endpackage

`default_nettype wire

[sv/wsp_csr.sv]
// Configuration register file of the wheel synchronizer drive.
// Depends on wsp_pkg for widths, index codes and reset values.
`default_nettype none

module wsp_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [wsp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [wsp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output wsp_pkg::wsp_cfg_type                  cfg
);

   wsp_pkg::wsp_cfg_type cfg_ff, cfg_in;

   // Decode the write into the addressed field; drop writes past the list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (wsp_pkg::csr_idx_type'(csr_index))
            wsp_pkg::CSR_TARGET: cfg_in.target       = csr_wdata[wsp_pkg::TARGET_W-1:0];
            wsp_pkg::CSR_SPEED:  cfg_in.base_speed   = csr_wdata[wsp_pkg::SPEED_W-1:0];
            wsp_pkg::CSR_GAIN_P: cfg_in.gain_p       = csr_wdata[wsp_pkg::GAIN_W-1:0];
            wsp_pkg::CSR_GAIN_I: cfg_in.gain_i       = csr_wdata[wsp_pkg::GAIN_W-1:0];
            wsp_pkg::CSR_GAIN_D: cfg_in.gain_d       = csr_wdata[wsp_pkg::GAIN_W-1:0];
            wsp_pkg::CSR_CAP:    cfg_in.integral_cap = csr_wdata[wsp_pkg::CAP_W-1:0];
            wsp_pkg::CSR_MARGIN: cfg_in.decel_margin = csr_wdata[wsp_pkg::TARGET_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target       <= wsp_pkg::TARGET_RST;
         cfg_ff.base_speed   <= wsp_pkg::SPEED_RST;
         cfg_ff.gain_p       <= wsp_pkg::GAIN_P_RST;
         cfg_ff.gain_i       <= wsp_pkg::GAIN_I_RST;
         cfg_ff.gain_d       <= wsp_pkg::GAIN_D_RST;
         cfg_ff.integral_cap <= wsp_pkg::CAP_RST;
         cfg_ff.decel_margin <= wsp_pkg::MARGIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[sv/wsp_mul.sv]
// Shared multiply-accumulate unit: registered 24x24 product, then an
// accumulator that either loads the product or adds it one chunk up.
// Depends on wsp_pkg for widths and the command struct.
`default_nettype none

module wsp_mul (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire wsp_pkg::wsp_mul_cmd_type   cmd,
   output logic [wsp_pkg::ACC_W-1:0]       acc
);

   logic [wsp_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                       valid_ff;
   logic                       hi_ff;
   logic [wsp_pkg::ACC_W-1:0]  acc_ff, acc_in;

   // Multiply stage
   assign prod_in = wsp_pkg::PROD_W'(cmd.a) * wsp_pkg::PROD_W'(cmd.b);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.valid;
      end
      prod_ff <= prod_in;
      hi_ff   <= cmd.acc_hi;
   end

   // Accumulate stage: load the low chunk, add the high chunk shifted up
   always_comb begin
      if (hi_ff) begin
         acc_in = acc_ff + {prod_ff[wsp_pkg::ACC_W-wsp_pkg::MUL_W-1:0],
                            {wsp_pkg::MUL_W{1'b0}}};
      end else begin
         acc_in = {{(wsp_pkg::ACC_W-wsp_pkg::PROD_W){1'b0}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

[sv/wsp_seq.sv]
// Sequencer of the wheel synchronizer drive: one-hot state machine and step
// counter that schedule the datapath and the shared multiplier.
// Depends on wsp_pkg for the step schedule and the control struct.
`default_nettype none

module wsp_seq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              eval_short,
   input  wire logic              out_free,
   output logic                   req_ready,
   output wsp_pkg::wsp_ctl_type   ctl
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_EVAL = 6'b000010,
      S_PREP = 6'b000100,
      S_MAGS = 6'b001000,
      S_RUN  = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   state_type                   state_ff, state_in;
   logic [wsp_pkg::STEP_W-1:0]  step_ff, step_in;

   // Next state and step
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = eval_short ? S_DONE : S_PREP;
         end
         S_PREP: begin
            state_in = S_MAGS;
         end
         S_MAGS: begin
            state_in = S_RUN;
            step_in  = '0;
         end
         S_RUN: begin
            if (step_ff == wsp_pkg::STEP_LAST) begin
               state_in = S_DONE;
            end else begin
               step_in = step_ff + wsp_pkg::STEP_W'(1);
            end
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Control outputs
   assign req_ready    = (state_ff == S_IDLE);
   assign ctl.accept   = req_valid && (state_ff == S_IDLE);
   assign ctl.eval     = (state_ff == S_EVAL);
   assign ctl.prep     = (state_ff == S_PREP);
   assign ctl.mags     = (state_ff == S_MAGS);
   assign ctl.run      = (state_ff == S_RUN);
   assign ctl.step     = step_ff;
   assign ctl.load_out = (state_ff == S_DONE) && out_free;

   // Step counter never runs past the schedule
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |-> (step_ff <= wsp_pkg::STEP_LAST))
      else $error("step counter past end of schedule");

   // An accepted item is evaluated in the next cycle
   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_EVAL))
      else $error("accepted item not evaluated");

   // The last step always hands over to result delivery
   a_run_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_RUN) && (step_ff == wsp_pkg::STEP_LAST)) |=> (state_ff == S_DONE))
      else $error("tick did not finish after last step");

   // A result is only loaded while the output register can take it
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      ctl.load_out |-> (state_ff == S_DONE) && out_free)
      else $error("result loaded into busy output");

endmodule

`default_nettype wire

[sv/wheel_sync_pid_drive.sv]
// Wheel synchronizer drive: top level with the datapath, register file,
// sequencer and shared multiplier. Depends on wsp_pkg, wsp_csr, wsp_mul, wsp_seq.
//
// One item at a time. A start item, or a tick once the target count is reached,
// goes from acceptance through evaluation straight to result delivery. A control
// tick runs through evaluate, prepare the error and its sum, take magnitudes,
// then 15 sequencer steps in which the one 24x24 multiplier runs ten passes
// (P, D and I terms in two chunks each, the two ratio scalings and the two
// divides by ten done as reciprocal multiplies). req_ready returns the cycle
// after the result is loaded, so a new item waits until the last result is loaded.
// Registers are written through csr_we/csr_index/csr_wdata while the block is idle
// (the user must keep to this; the block does not enforce it); no reset pass is needed.
`default_nettype none

module wheel_sync_pid_drive (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_mode,
   input  wire logic signed [wsp_pkg::COUNT_BITS-1:0] req_left_count,
   input  wire logic signed [wsp_pkg::COUNT_BITS-1:0] req_right_count,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [wsp_pkg::DRIVE_W-1:0]         rsp_left_drive,
   output logic signed [wsp_pkg::DRIVE_W-1:0]         rsp_right_drive,
   output logic                                       rsp_done_res,
   input  wire logic                                  csr_we,
   input  wire logic [wsp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [wsp_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int CMP_W   = wsp_pkg::CMP_W;
   localparam int ERR_W   = wsp_pkg::ERR_W;
   localparam int DIFF_W  = wsp_pkg::DIFF_W;
   localparam int SUM_W   = wsp_pkg::SUM_W;
   localparam int LSUM_W  = wsp_pkg::LSUM_W;
   localparam int TERM_W  = wsp_pkg::TERM_W;
   localparam int CLAMP_W = wsp_pkg::CLAMP_W;
   localparam int QUOT_W  = wsp_pkg::QUOT_W;
   localparam int MUL_W   = wsp_pkg::MUL_W;
   localparam int MAG_W   = wsp_pkg::MAG_W;
   localparam int SPEED_W = wsp_pkg::SPEED_W;
   localparam int DRIVE_W = wsp_pkg::DRIVE_W;
   localparam int ITOP_W  = wsp_pkg::ACC_W - wsp_pkg::TERM_SHIFT;

   localparam logic signed [LSUM_W-1:0] CLAMP_HI = LSUM_W'(2**(CLAMP_W-1) - 1);
   localparam logic signed [LSUM_W-1:0] CLAMP_LO = LSUM_W'(-(2**(CLAMP_W-1)));
   localparam logic signed [QUOT_W:0]   DRV_MAX  = (QUOT_W+1)'(2**(DRIVE_W-1) - 1);
   localparam logic signed [QUOT_W:0]   DRV_MIN  = (QUOT_W+1)'(-(2**(DRIVE_W-1)));

   wsp_pkg::wsp_cfg_type     cfg;
   wsp_pkg::wsp_ctl_type     ctl;
   wsp_pkg::wsp_mul_cmd_type cmd;
   logic [wsp_pkg::ACC_W-1:0] acc;

   logic eval_short;
   logic out_free;

   // Captured item
   logic                            mode_ff;
   logic [wsp_pkg::COUNT_BITS-1:0]  left_ff, right_ff;

   // Controller state
   logic                            finished_ff, finished_in;
   logic [ERR_W-1:0]                prev_ff, prev_in;
   logic [SUM_W-1:0]                sum_ff, sum_in;
   logic [wsp_pkg::RATIO_W-1:0]     ratio_ff, ratio_in;

   // Working registers of one tick
   logic [ERR_W-1:0]                err_ff;
   logic [DIFF_W-1:0]               diff_ff;
   logic [ERR_W-1:0]                mag_p_ff;
   logic [DIFF_W-1:0]               mag_d_ff;
   logic [SUM_W-1:0]                mag_i_ff;
   logic                            neg_p_ff, neg_d_ff, neg_i_ff;
   logic [LSUM_W-1:0]               lsum_ff, lsum_in;
   logic [CLAMP_W-1:0]              lmag_ff;
   logic                            lneg_ff;
   logic [SPEED_W-1:0]              bmag_ff;
   logic                            bneg_ff;

   // Pending result and output register
   logic [DRIVE_W-1:0]              res_left_ff, res_left_in;
   logic [DRIVE_W-1:0]              res_right_ff, res_right_in;
   logic                            res_done_ff, res_done_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [DRIVE_W-1:0]              rsp_left_ff, rsp_right_ff;
   logic                            rsp_done_ff;

   // Compare and error signals
   logic signed [CMP_W-1:0] left_w, right_w, tgt_w, margin_w, thresh_w, twice_w;
   logic                    reached;
   logic [ERR_W-1:0]        err_calc;
   logic [DIFF_W-1:0]       diff_calc;
   logic [SUM_W:0]          sum_calc;
   logic [SUM_W-1:0]        sum_sat;

   // Magnitude extensions feeding the multiplier
   logic [MAG_W-1:0]        mag_p_x, mag_d_x, mag_i_x;

   // Term accumulation
   logic [TERM_W-1:0]       tmag;
   logic                    tneg;
   logic [LSUM_W-1:0]       tval;
   logic [ITOP_W-1:0]       itop;
   logic [wsp_pkg::CAP_W-1:0] imag;

   // Drive results
   logic [QUOT_W-1:0]       quot;
   logic [QUOT_W:0]         rval, lval;
   logic [wsp_pkg::RATIO_W-1:0] ratio_up, ratio_next;
   logic                    ratio_inc, ratio_dec;

   wsp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wsp_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .eval_short (eval_short),
      .out_free   (out_free),
      .req_ready  (req_ready),
      .ctl        (ctl)
   );

   wsp_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .acc   (acc)
   );

   // Hold the accepted item
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         mode_ff  <= req_mode;
         left_ff  <= req_left_count;
         right_ff <= req_right_count;
      end
   end

   // Signed compares against the target
   assign left_w   = {{(CMP_W-wsp_pkg::COUNT_BITS){left_ff[wsp_pkg::COUNT_BITS-1]}}, left_ff};
   assign right_w  = {{(CMP_W-wsp_pkg::COUNT_BITS){right_ff[wsp_pkg::COUNT_BITS-1]}},
                      right_ff};
   assign tgt_w    = {{(CMP_W-wsp_pkg::TARGET_W){1'b0}}, cfg.target};
   assign margin_w = {{(CMP_W-wsp_pkg::TARGET_W){1'b0}}, cfg.decel_margin};
   assign thresh_w = tgt_w - margin_w;
   assign twice_w  = left_w <<< 1;
   assign reached  = (left_w >= tgt_w);

   assign eval_short = (mode_ff == wsp_pkg::MODE_START) || finished_ff || reached;

   // Error, derivative difference and saturated sum
   assign err_calc  = left_w[ERR_W-1:0] - right_w[ERR_W-1:0];
   assign diff_calc = {prev_ff[ERR_W-1], prev_ff} - {err_ff[ERR_W-1], err_ff};
   assign sum_calc  = {sum_ff[SUM_W-1], sum_ff}
                    + {{(SUM_W+1-ERR_W){err_ff[ERR_W-1]}}, err_ff};

   always_comb begin
      if (sum_calc[SUM_W] != sum_calc[SUM_W-1]) begin
         sum_sat = sum_calc[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_sat = sum_calc[SUM_W-1:0];
      end
   end

   // Controller state update
   always_comb begin
      finished_in = finished_ff;
      prev_in     = prev_ff;
      sum_in      = sum_ff;
      ratio_in    = ratio_ff;
      if (ctl.eval && (mode_ff == wsp_pkg::MODE_START)) begin
         finished_in = 1'b0;
         prev_in     = '0;
         sum_in      = '0;
         ratio_in    = wsp_pkg::RATIO_START;
      end else if (ctl.eval && eval_short) begin
         finished_in = 1'b1;
      end
      if (ctl.prep) begin
         prev_in = err_ff;
         sum_in  = sum_sat;
      end
      if (ctl.run && (ctl.step == wsp_pkg::STEP_OUT_L)) begin
         ratio_in = ratio_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         finished_ff <= 1'b0;
         prev_ff     <= '0;
         sum_ff      <= '0;
         ratio_ff    <= wsp_pkg::RATIO_START;
      end else begin
         finished_ff <= finished_in;
         prev_ff     <= prev_in;
         sum_ff      <= sum_in;
         ratio_ff    <= ratio_in;
      end
   end

   // Ramp the ratio up in the first half, down near the end
   assign ratio_inc  = (ratio_ff < wsp_pkg::RATIO_MAX) && (twice_w < tgt_w);
   assign ratio_up   = ratio_ff + wsp_pkg::RATIO_W'(ratio_inc);
   assign ratio_dec  = (left_w > thresh_w) && (ratio_up >= wsp_pkg::RATIO_FLOOR);
   assign ratio_next = ratio_up - wsp_pkg::RATIO_W'(ratio_dec);

   // Latch error, difference, magnitudes and base speed
   always_ff @(posedge clock) begin
      if (ctl.eval) begin
         err_ff <= err_calc;
      end
      if (ctl.prep) begin
         diff_ff <= diff_calc;
         bneg_ff <= cfg.base_speed[SPEED_W-1];
         bmag_ff <= cfg.base_speed[SPEED_W-1] ? -cfg.base_speed : cfg.base_speed;
      end
      if (ctl.mags) begin
         neg_p_ff <= err_ff[ERR_W-1];
         mag_p_ff <= err_ff[ERR_W-1] ? -err_ff : err_ff;
         neg_d_ff <= diff_ff[DIFF_W-1];
         mag_d_ff <= diff_ff[DIFF_W-1] ? -diff_ff : diff_ff;
         neg_i_ff <= sum_ff[SUM_W-1];
         mag_i_ff <= sum_ff[SUM_W-1] ? -sum_ff : sum_ff;
      end
   end

   assign mag_p_x = {{(MAG_W-ERR_W){1'b0}}, mag_p_ff};
   assign mag_d_x = {{(MAG_W-DIFF_W){1'b0}}, mag_d_ff};
   assign mag_i_x = {{(MAG_W-SUM_W){1'b0}}, mag_i_ff};

   // Issue multiplies by step
   always_comb begin
      cmd        = '0;
      cmd.valid  = 1'b0;
      if (ctl.run) begin
         case (ctl.step)
            wsp_pkg::STEP_P_LO: begin
               cmd.valid = 1'b1;
               cmd.a     = mag_p_x[MUL_W-1:0];
               cmd.b     = cfg.gain_p;
            end
            wsp_pkg::STEP_P_HI: begin
               cmd.valid  = 1'b1;
               cmd.acc_hi = 1'b1;
               cmd.a      = mag_p_x[MAG_W-1:MUL_W];
               cmd.b      = cfg.gain_p;
            end
            wsp_pkg::STEP_D_LO: begin
               cmd.valid = 1'b1;
               cmd.a     = mag_d_x[MUL_W-1:0];
               cmd.b     = cfg.gain_d;
            end
            wsp_pkg::STEP_D_HI: begin
               cmd.valid  = 1'b1;
               cmd.acc_hi = 1'b1;
               cmd.a      = mag_d_x[MAG_W-1:MUL_W];
               cmd.b      = cfg.gain_d;
            end
            wsp_pkg::STEP_I_LO: begin
               cmd.valid = 1'b1;
               cmd.a     = mag_i_x[MUL_W-1:0];
               cmd.b     = cfg.gain_i;
            end
            wsp_pkg::STEP_I_HI: begin
               cmd.valid  = 1'b1;
               cmd.acc_hi = 1'b1;
               cmd.a      = mag_i_x[MAG_W-1:MUL_W];
               cmd.b      = cfg.gain_i;
            end
            wsp_pkg::STEP_MUL_R: begin
               cmd.valid = 1'b1;
               cmd.a     = {{(MUL_W-CLAMP_W){1'b0}}, lmag_ff};
               cmd.b     = {{(MUL_W-wsp_pkg::RATIO_W){1'b0}}, ratio_ff};
            end
            wsp_pkg::STEP_MUL_L: begin
               cmd.valid = 1'b1;
               cmd.a     = {{(MUL_W-SPEED_W){1'b0}}, bmag_ff};
               cmd.b     = {{(MUL_W-wsp_pkg::RATIO_W){1'b0}}, ratio_ff};
            end
            wsp_pkg::STEP_DIV_R, wsp_pkg::STEP_DIV_L: begin
               cmd.valid = 1'b1;
               cmd.a     = acc[MUL_W-1:0];
               cmd.b     = wsp_pkg::RECIP_TEN;
            end
            default: ;
         endcase
      end
   end

   // Clamp the integral term magnitude to the cap
   assign itop = acc[wsp_pkg::ACC_W-1:wsp_pkg::TERM_SHIFT];
   assign imag = (itop > ITOP_W'(cfg.integral_cap)) ? cfg.integral_cap
               : itop[wsp_pkg::CAP_W-1:0];

   // Select the finished term and its sign
   always_comb begin
      case (ctl.step)
         wsp_pkg::STEP_USE_P: begin
            tmag = acc[wsp_pkg::TERM_SHIFT +: TERM_W];
            tneg = neg_p_ff;
         end
         wsp_pkg::STEP_USE_D: begin
            tmag = acc[wsp_pkg::TERM_SHIFT +: TERM_W];
            tneg = neg_d_ff;
         end
         default: begin
            tmag = {{(TERM_W-wsp_pkg::CAP_W){1'b0}}, imag};
            tneg = neg_i_ff;
         end
      endcase
   end

   assign tval = {{(LSUM_W-TERM_W){1'b0}}, tmag};

   // Add terms onto the base speed
   always_comb begin
      lsum_in = lsum_ff;
      if (ctl.prep) begin
         lsum_in = {{(LSUM_W-SPEED_W){cfg.base_speed[SPEED_W-1]}}, cfg.base_speed};
      end else if (ctl.run && ((ctl.step == wsp_pkg::STEP_USE_P)
                               || (ctl.step == wsp_pkg::STEP_USE_D)
                               || (ctl.step == wsp_pkg::STEP_USE_I))) begin
         lsum_in = tneg ? (lsum_ff - tval) : (lsum_ff + tval);
      end
   end

   always_ff @(posedge clock) begin
      lsum_ff <= lsum_in;
   end

   // Clamp the right sum to a range that still saturates, then take its magnitude
   always_ff @(posedge clock) begin
      if (ctl.run && (ctl.step == wsp_pkg::STEP_CLAMP)) begin
         if ($signed(lsum_ff) > CLAMP_HI) begin
            lneg_ff <= 1'b0;
            lmag_ff <= CLAMP_HI[CLAMP_W-1:0];
         end else if ($signed(lsum_ff) < CLAMP_LO) begin
            lneg_ff <= 1'b1;
            lmag_ff <= {1'b1, {(CLAMP_W-1){1'b0}}};
         end else begin
            lneg_ff <= lsum_ff[LSUM_W-1];
            lmag_ff <= lsum_ff[LSUM_W-1] ? (-lsum_ff[CLAMP_W-1:0]) : lsum_ff[CLAMP_W-1:0];
         end
      end
   end

   // Quotients by ten, with sign restored
   assign quot = acc[wsp_pkg::RECIP_SHIFT +: QUOT_W];
   assign rval = lneg_ff ? -{1'b0, quot} : {1'b0, quot};
   assign lval = bneg_ff ? -{1'b0, quot} : {1'b0, quot};

   // Build the pending result
   always_comb begin
      res_left_in  = res_left_ff;
      res_right_in = res_right_ff;
      res_done_in  = res_done_ff;
      if (ctl.eval) begin
         res_left_in  = '0;
         res_right_in = '0;
         res_done_in  = (mode_ff != wsp_pkg::MODE_START) && (finished_ff || reached);
      end else if (ctl.run && (ctl.step == wsp_pkg::STEP_OUT_R)) begin
         if ($signed(rval) > DRV_MAX) begin
            res_right_in = DRV_MAX[DRIVE_W-1:0];
         end else if ($signed(rval) < DRV_MIN) begin
            res_right_in = DRV_MIN[DRIVE_W-1:0];
         end else begin
            res_right_in = rval[DRIVE_W-1:0];
         end
      end else if (ctl.run && (ctl.step == wsp_pkg::STEP_OUT_L)) begin
         res_left_in = lval[DRIVE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      res_left_ff  <= res_left_in;
      res_right_ff <= res_right_in;
      res_done_ff  <= res_done_in;
   end

   // Output register: load the result, drop valid once taken
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         rsp_left_ff  <= res_left_ff;
         rsp_right_ff <= res_right_ff;
         rsp_done_ff  <= res_done_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_drive  = rsp_left_ff;
   assign rsp_right_drive = rsp_right_ff;
   assign rsp_done_res    = rsp_done_ff;

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the wheel synchronizer drive. It predicts each result item
// from its own copy of the controller state, or uses a directed row's typed expectation,
// and compares it with the block's output. Depends on wsp_pkg and wheel_sync_pid_drive.
`timescale 1ns / 100ps

module testbench;

   localparam int COUNT_BITS     = wsp_pkg::COUNT_BITS;
   localparam int GAIN_FRAC_BITS = wsp_pkg::GAIN_FRAC_BITS;
   localparam int DRIVE_W        = wsp_pkg::DRIVE_W;
   localparam int CSR_IDX_W      = wsp_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W     = wsp_pkg::CSR_DATA_W;
   localparam int TARGET_W       = wsp_pkg::TARGET_W;
   localparam int SPEED_W        = wsp_pkg::SPEED_W;
   localparam int GAIN_W         = wsp_pkg::GAIN_W;
   localparam int CAP_W          = wsp_pkg::CAP_W;

   localparam logic MODE_START = wsp_pkg::MODE_START;
   localparam logic MODE_TICK = ~wsp_pkg::MODE_START;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 40;
   localparam int SAT_TICKS = 30;
   localparam int PHASE_ITEMS = 65;
   localparam longint COUNT_MAX = 8388607;
   localparam longint COUNT_MIN = -8388608;
   localparam longint SUM_HI = (longint'(1) <<< 39) - 1;
   localparam longint SUM_LO = -(longint'(1) <<< 39);
   localparam longint DRIVE_HI = 32767;
   localparam longint DRIVE_LO = -32768;
   localparam longint RATIO_RESET = 3;
   localparam longint RATIO_TOP = 10;
   localparam longint RATIO_SLOW_MIN = 3;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] left_drive;
      logic signed [DRIVE_W-1:0] right_drive;
      logic                      done;
   } drive_result_type;

   typedef struct {
      logic             mode;
      int               left;
      int               right;
      bit               typed;
      drive_result_type want;
   } stim_row_type;

   // Ports
   logic                         clock;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_mode = MODE_START;
   logic signed [COUNT_BITS-1:0] req_left_count = '0;
   logic signed [COUNT_BITS-1:0] req_right_count = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [DRIVE_W-1:0]    rsp_left_drive;
   logic signed [DRIVE_W-1:0]    rsp_right_drive;
   logic                         rsp_done_res;
   logic                         csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]         csr_index = '0;
   logic [CSR_DATA_W-1:0]        csr_wdata = '0;

   // Controller copy: registers and state
   wsp_pkg::wsp_cfg_type drive_cfg = '{TARGET_W'(13367), SPEED_W'(13107), GAIN_W'(21810),
                                       GAIN_W'(7214), GAIN_W'(1174), CAP_W'(1311),
                                       TARGET_W'(5347)};
   longint ctl_prev_err = 0;
   longint ctl_err_sum = 0;
   longint ctl_ratio = RATIO_RESET;
   bit     ctl_finished = 1'b0;

   drive_result_type pending_drives [$];
   int cycle_count = 0;
   int mismatch_count = 0;
   int items_sent = 0;
   int send_gap_pct = 0;
   int rsp_stall_pct = 0;

   // Directed items: reset state, extremes, saturation both ways, done and its hold
   stim_row_type directed_rows [0:17] = '{
      '{MODE_TICK,        0,        0, 1'b1, '{16'sd3932, 16'sd3932, 1'b0}},
      '{MODE_START,       0,        0, 1'b1, '{16'sd0, 16'sd0, 1'b0}},
      '{MODE_TICK,        0,        0, 1'b1, '{16'sd3932, 16'sd3932, 1'b0}},
      '{MODE_TICK,     1500,     1400, 1'b0, '0},
      '{MODE_TICK,     3000,     3400, 1'b0, '0},
      '{MODE_TICK, -8388608,  8388607, 1'b0, '0},
      '{MODE_TICK,     6000, -8388608, 1'b0, '0},
      '{MODE_TICK,     6600,  8388607, 1'b0, '0},
      '{MODE_TICK,     9000,     8800, 1'b0, '0},
      '{MODE_TICK,    12000,    12100, 1'b0, '0},
      '{MODE_TICK,    13366,    13300, 1'b0, '0},
      '{MODE_TICK,    13367,    13367, 1'b1, '{16'sd0, 16'sd0, 1'b1}},
      '{MODE_TICK,       -5,        0, 1'b1, '{16'sd0, 16'sd0, 1'b1}},
      '{MODE_START,       0,        0, 1'b1, '{16'sd0, 16'sd0, 1'b0}},
      '{MODE_TICK,  8388607, -8388608, 1'b1, '{16'sd0, 16'sd0, 1'b1}},
      '{MODE_START, 8388607, -8388608, 1'b1, '{16'sd0, 16'sd0, 1'b0}},
      '{MODE_TICK,        0,        0, 1'b1, '{16'sd3932, 16'sd3932, 1'b0}},
      '{MODE_TICK,  8388607,  8388607, 1'b1, '{16'sd0, 16'sd0, 1'b1}}
   };

   wheel_sync_pid_drive i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_left_count  (req_left_count),
      .req_right_count (req_right_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_drive  (rsp_left_drive),
      .rsp_right_drive (rsp_right_drive),
      .rsp_done_res    (rsp_done_res),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Scale a value by a Q0.24 gain into Q1.15, truncating the magnitude
   function automatic longint gain_scale(longint value, longint unsigned gain);
      longint unsigned mag;
      mag = (value < 0) ? -value : value;
      mag = (mag * gain) >> (GAIN_FRAC_BITS - 15);
      return (value < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   // Advance the controller copy by one item and return the drive it commands
   function automatic drive_result_type next_drive(logic mode,
                                                   logic signed [COUNT_BITS-1:0] l,
                                                   logic signed [COUNT_BITS-1:0] r);
      longint left, right, err, tgt, p_term, i_term, d_term, cap, speed, lsum, ldrv, rdrv;
      drive_result_type res;
      res = '0;
      if (mode == MODE_START) begin
         ctl_prev_err = 0;
         ctl_err_sum = 0;
         ctl_ratio = RATIO_RESET;
         ctl_finished = 1'b0;
         return res;
      end
      left = l;
      right = r;
      tgt = drive_cfg.target;
      if (ctl_finished || left >= tgt) begin
         ctl_finished = 1'b1;
         res.done = 1'b1;
         return res;
      end
      err = left - right;
      p_term = gain_scale(err, drive_cfg.gain_p);
      d_term = gain_scale(ctl_prev_err - err, drive_cfg.gain_d);
      ctl_prev_err = err;
      ctl_err_sum += err;
      if (ctl_err_sum > SUM_HI) ctl_err_sum = SUM_HI;
      if (ctl_err_sum < SUM_LO) ctl_err_sum = SUM_LO;
      i_term = gain_scale(ctl_err_sum, drive_cfg.gain_i);
      cap = drive_cfg.integral_cap;
      if (i_term > cap) i_term = cap;
      if (i_term < -cap) i_term = -cap;
      speed = $signed(drive_cfg.base_speed);
      ldrv = speed * ctl_ratio / 10;
      lsum = speed + p_term + i_term + d_term;
      rdrv = lsum * ctl_ratio / 10;
      if (rdrv > DRIVE_HI) rdrv = DRIVE_HI;
      if (rdrv < DRIVE_LO) rdrv = DRIVE_LO;
      // Ramp up in the first half, back down near the end
      if (ctl_ratio < RATIO_TOP && 2 * left < tgt) ctl_ratio++;
      if (left > tgt - longint'(drive_cfg.decel_margin) && ctl_ratio >= RATIO_SLOW_MIN)
         ctl_ratio--;
      res.left_drive = ldrv[DRIVE_W-1:0];
      res.right_drive = rdrv[DRIVE_W-1:0];
      return res;
   endfunction

   function automatic wsp_pkg::wsp_cfg_type pick_config(int kind);
      wsp_pkg::wsp_cfg_type c;
      case (kind)
         0: c = '{TARGET_W'(13367), SPEED_W'(13107), GAIN_W'(21810), GAIN_W'(7214),
                  GAIN_W'(1174), CAP_W'(1311), TARGET_W'(5347)};
         1: c = '{'1, SPEED_W'(32767), '1, '1, '1, '1, '1};
         2: c = '{'0, SPEED_W'(16'h8000), '0, '0, '0, '0, '0};
         default: begin
            c.target = ($urandom_range(0, 3) == 0) ? TARGET_W'($urandom)
                                                  : TARGET_W'($urandom_range(300, 40000));
            c.base_speed = SPEED_W'($urandom);
            c.gain_p = GAIN_W'($urandom >> $urandom_range(8, 28));
            c.gain_i = GAIN_W'($urandom >> $urandom_range(8, 28));
            c.gain_d = GAIN_W'($urandom >> $urandom_range(8, 28));
            c.integral_cap = CAP_W'($urandom);
            c.decel_margin = TARGET_W'($urandom_range(0, c.target));
         end
      endcase
      return c;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // Write every register in index order, then update the copy
   task automatic load_config(input wsp_pkg::wsp_cfg_type c);
      logic [CSR_DATA_W-1:0] value;
      for (int k = wsp_pkg::CSR_TARGET; k <= wsp_pkg::CSR_MARGIN; k++) begin
         case (wsp_pkg::csr_idx_type'(k))
            wsp_pkg::CSR_TARGET: value = CSR_DATA_W'(c.target);
            wsp_pkg::CSR_SPEED:  value = CSR_DATA_W'(c.base_speed);
            wsp_pkg::CSR_GAIN_P: value = CSR_DATA_W'(c.gain_p);
            wsp_pkg::CSR_GAIN_I: value = CSR_DATA_W'(c.gain_i);
            wsp_pkg::CSR_GAIN_D: value = CSR_DATA_W'(c.gain_d);
            wsp_pkg::CSR_CAP:    value = CSR_DATA_W'(c.integral_cap);
            wsp_pkg::CSR_MARGIN: value = CSR_DATA_W'(c.decel_margin);
            default:             value = '0;
         endcase
         csr_we <= 1'b1;
         csr_index <= CSR_IDX_W'(k);
         csr_wdata <= value;
         @(posedge clock);
      end
      csr_we <= 1'b0;
      drive_cfg = c;
   endtask

   // Offer one item, hold it until accepted, then queue its expected drive
   task automatic send_item(input logic mode, input logic signed [COUNT_BITS-1:0] left,
                            input logic signed [COUNT_BITS-1:0] right,
                            input bit typed, input drive_result_type typed_drive);
      int gap;
      drive_result_type predicted;
      gap = 0;
      if (send_gap_pct != 0)
         while ($urandom_range(0, 99) < send_gap_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_left_count <= left;
      req_right_count <= right;
      do @(posedge clock); while (!req_ready);
      predicted = next_drive(mode, left, right);
      pending_drives.push_back(typed ? typed_drive : predicted);
      items_sent++;
   endtask

   // Drop valid and wait until every expected item has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // One move: start, then up to 40 ticks with the left count climbing toward the target, ending two ticks past it
   task automatic run_move();
      longint tgt, stride, spread, left, right;
      int past_end;
      send_item(MODE_START, COUNT_BITS'($urandom), COUNT_BITS'($urandom), 1'b0, '0);
      tgt = drive_cfg.target;
      stride = tgt / $urandom_range(4, 20) + 1;
      spread = longint'(1) << $urandom_range(0, 14);
      left = ($urandom_range(0, 3) == 0) ? -longint'($urandom_range(0, 200)) : 0;
      past_end = 0;
      for (int t = 0; t < 40 && past_end < 2; t++) begin
         right = left + longint'($urandom_range(0, 2 * spread)) - spread;
         if (right > COUNT_MAX) right = COUNT_MAX;
         if (right < COUNT_MIN) right = COUNT_MIN;
         // Break the move now and then with a stray start
         if ($urandom_range(0, 99) < 4)
            send_item(MODE_START, COUNT_BITS'($urandom), COUNT_BITS'($urandom), 1'b0, '0);
         send_item(MODE_TICK, COUNT_BITS'(left), COUNT_BITS'(right), 1'b0, '0);
         if (left >= tgt) past_end++;
         left = left + stride * longint'($urandom_range(50, 150)) / 100;
         if (left > COUNT_MAX) left = COUNT_MAX;
      end
   endtask

   // Receiver stalls
   always @(posedge clock)
      rsp_ready <= (rsp_stall_pct == 0) || ($urandom_range(0, 99) >= rsp_stall_pct);

   // Compare each result item with the oldest expectation
   always @(posedge clock) begin
      drive_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_drives.size() == 0) begin
            report_mismatch("result item with none expected");
         end else begin
            want = pending_drives.pop_front();
            if (rsp_left_drive !== want.left_drive)
               report_mismatch($sformatf("left_drive got %0d want %0d",
                                         rsp_left_drive, want.left_drive));
            if (rsp_right_drive !== want.right_drive)
               report_mismatch($sformatf("right_drive got %0d want %0d",
                                         rsp_right_drive, want.right_drive));
            if (rsp_done_res !== want.done)
               report_mismatch($sformatf("done_res got %0b want %0b",
                                         rsp_done_res, want.done));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int phase_start;
      wsp_pkg::wsp_cfg_type sat_cfg;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed items with reset registers, no idling
      foreach (directed_rows[k])
         send_item(directed_rows[k].mode, COUNT_BITS'(directed_rows[k].left),
                   COUNT_BITS'(directed_rows[k].right), directed_rows[k].typed,
                   directed_rows[k].want);
      drain_results();

      // Hold the error at its widest for a while, then reverse it
      sat_cfg = pick_config(3);
      sat_cfg.target = '1;
      sat_cfg.decel_margin = '0;
      load_config(sat_cfg);
      send_item(MODE_START, '0, '0, 1'b0, '0);
      repeat (SAT_TICKS)
         send_item(MODE_TICK, COUNT_BITS'(COUNT_MAX - 1), COUNT_BITS'(COUNT_MIN), 1'b0, '0);
      repeat (4)
         send_item(MODE_TICK, COUNT_BITS'(COUNT_MIN), COUNT_BITS'(COUNT_MAX), 1'b0, '0);

      // Random phases: register settings rotate, idling pattern cycles through four
      for (int phase = 0; phase < 8; phase++) begin
         drain_results();
         load_config(pick_config(phase));
         case (phase % 4)
            0: begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_gap_pct = 61; rsp_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  rsp_stall_pct = 61; end
            default: begin send_gap_pct = 29; rsp_stall_pct = 29; end
         endcase
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 85)
               run_move();
            else
               send_item(logic'($urandom_range(0, 1)), COUNT_BITS'($urandom),
                         COUNT_BITS'($urandom), 1'b0, '0);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_drives.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
